// ===== sv/nbrc_pkg.sv =====
// ----------------------------------------------------------------------------
// nbrc_pkg
// Shared types and constants for the nested box refinement classifier.
// ----------------------------------------------------------------------------
package nbrc_pkg;

  localparam int MAX_TURBINES = 16;
  localparam int MAX_LEVELS   = 8;
  localparam int TURB_W       = $clog2(MAX_TURBINES);
  localparam int LIDX_W       = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int NT_W         = 5;   // num_turbines register
  localparam int NL_W         = 4;   // num_levels register
  localparam int CNT_W        = $clog2(MAX_TURBINES + 1);
  localparam int DEPTH_W      = $clog2(MAX_LEVELS + 1);
  localparam int FRAC_W       = 17;
  localparam int NUM_W        = DEPTH_W + 16;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        lx;
    logic [30:0]        ly;
    logic [30:0]        lz;
  } box_t;

  typedef struct packed {
    logic              en;
    logic [TURB_W-1:0] turbine;
    logic [LIDX_W-1:0] level;
    box_t              box;
  } wr_t;

  // one turbine walking down the row of level cells
  typedef struct packed {
    logic               valid;
    logic               alive;
    logic [TURB_W-1:0]  turbine;
    logic [DEPTH_W-1:0] depth;
  } tok_t;

  typedef struct packed {
    logic [NL_W-1:0]    nl;
    logic [30:0]        tol;
    logic signed [15:0] axis_a;
    logic signed [15:0] axis_b;
  } geo_t;

endpackage

// ===== sv/nested_box_refine_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// nested_box_refine_classifier_unit
// Nested refinement box table with point classification over a row of
// level cells, one cell per level, turbines streamed through the row.
// ----------------------------------------------------------------------------
// Box write: taken while idle, no result transaction; writes go back to back.
// Query: the result is formed from one token per turbine sent through the
//   four-stage cell pipeline, then the bit-per-cycle divider; one query in
//   flight at a time, next transaction taken once the done state has passed,
//   which holds while an earlier result is still waiting to leave.
// Reset (rst_n, synchronous): control state, config registers and tokens to defaults; the
//   box table is undefined until written and is not cleared.
module nested_box_refine_classifier_unit
  import nbrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // turbine, level, pos_x, pos_y, pos_z, len_x, len_y, len_z, zero pad
  input  logic [199:0] in_tdata,
  // op
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // refine_level, level_ratio, zero pad
  output logic [23:0]  out_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [2:0] REG_NT  = 3'd0;
  localparam logic [2:0] REG_NL  = 3'd1;
  localparam logic [2:0] REG_TOL = 3'd2;
  localparam logic [2:0] REG_AA  = 3'd3;
  localparam logic [2:0] REG_AB  = 3'd4;

  logic [NT_W-1:0]    nt_r;
  logic [NL_W-1:0]    nl_r;
  logic [30:0]        tol_r;
  logic signed [15:0] aa_r, ab_r;
  logic signed [31:0] px_r, py_r, pz_r;

  logic               acc, idle;
  logic [3:0]         f_turbine;
  logic [2:0]         f_level;
  wr_t                wr;
  geo_t               geo;
  tok_t               tok [MAX_LEVELS+1];
  logic [DEPTH_W-1:0] res_level;
  logic [FRAC_W-1:0]  res_frac;

  assign pready = 1'b1;
  assign acc    = in_tvalid && in_tready;
  assign in_tready = idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nt_r  <= NT_W'(1);
      nl_r  <= NL_W'(1);
      tol_r <= '0;
      aa_r  <= '0;
      ab_r  <= -16'sd16384;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_NT:  nt_r  <= pwdata[NT_W-1:0];
        REG_NL:  nl_r  <= pwdata[NL_W-1:0];
        REG_TOL: tol_r <= pwdata[30:0];
        REG_AA:  aa_r  <= pwdata[15:0];
        REG_AB:  ab_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_NT:  prdata = 32'(nt_r);
      REG_NL:  prdata = 32'(nl_r);
      REG_TOL: prdata = 32'(tol_r);
      REG_AA:  prdata = {{16{aa_r[15]}}, aa_r};
      REG_AB:  prdata = {{16{ab_r[15]}}, ab_r};
      default: prdata = '0;
    endcase
  end

  assign f_turbine = in_tdata[3:0];
  assign f_level   = in_tdata[6:4];

  always_comb begin
    wr.en      = acc && !in_tuser[0] && (32'(f_turbine) < MAX_TURBINES)
                 && (32'(f_level) < MAX_LEVELS);
    wr.turbine = f_turbine[TURB_W-1:0];
    wr.level   = f_level[LIDX_W-1:0];
    wr.box.cx  = in_tdata[38:7];
    wr.box.cy  = in_tdata[70:39];
    wr.box.cz  = in_tdata[102:71];
    wr.box.lx  = in_tdata[133:103];
    wr.box.ly  = in_tdata[164:134];
    wr.box.lz  = in_tdata[195:165];
    geo.nl     = nl_r;
    geo.tol    = tol_r;
    geo.axis_a = aa_r;
    geo.axis_b = ab_r;
  end

  // query point held for the whole walk
  always_ff @(posedge clk) begin
    if (acc && in_tuser[0]) begin
      px_r <= in_tdata[38:7];
      py_r <= in_tdata[70:39];
      pz_r <= in_tdata[102:71];
    end
  end

  nbrc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .query_go     (acc && in_tuser[0]),
    .num_turbines (nt_r),
    .num_levels   (nl_r),
    .idle         (idle),
    .tok_head     (tok[0]),
    .tok_tail     (tok[MAX_LEVELS]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .res_level    (res_level),
    .res_frac     (res_frac)
  );

  for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
    nbrc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_level (LIDX_W'(g)),
      .wr         (wr),
      .geo        (geo),
      .pt_x       (px_r),
      .pt_y       (py_r),
      .pt_z       (pz_r),
      .tok_in     (tok[g]),
      .tok_out    (tok[g+1])
    );
  end

  assign out_tdata = {3'b0, res_frac, res_level};

endmodule

// ===== sv/nbrc_cell.sv =====
// ----------------------------------------------------------------------------
// nbrc_cell
// One refinement level: holds that level's box for every turbine and tests
// the query point against it as a turbine token passes through.
// ----------------------------------------------------------------------------
module nbrc_cell
  import nbrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [LIDX_W-1:0]  cell_level,
  input  wr_t                wr,
  input  geo_t               geo,
  input  logic signed [31:0] pt_x,
  input  logic signed [31:0] pt_y,
  input  logic signed [31:0] pt_z,
  input  tok_t               tok_in,
  output tok_t               tok_out
);

  box_t mem [MAX_TURBINES];

  tok_t tok1_r, tok2_r, tok3_r, tok4_r;
  box_t box_r;
  logic signed [31:0] dx_r, dy_r, dz_r, dz3_r;
  logic [30:0] lx2_r, ly2_r, lz2_r, lx3_r, ly3_r, lz3_r;
  logic signed [47:0] pax_r, pby_r, pay_r, pbx_r;

  logic signed [31:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [48:0] sx, sy;
  logic signed [49:0] vx, vy, vz, lo;
  logic hit;
  logic deeper;

  function automatic logic signed [31:0] sat_sub(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      sat_sub = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_sub = d[31:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (wr.en && wr.level == cell_level) begin
      mem[wr.turbine] <= wr.box;
    end
    box_r <= mem[tok_in.turbine];
  end

  always_comb begin
    dx_nxt = sat_sub(pt_x, box_r.cx);
    dy_nxt = sat_sub(pt_y, box_r.cy);
    dz_nxt = sat_sub(pt_z, box_r.cz);
  end

  // last stage: finish rotation into box frame, floor shift, range test
  always_comb begin
    sx = 49'(pax_r) + 49'(pby_r);
    sy = 49'(pay_r) - 49'(pbx_r);
    vx = 50'(sx >>> 14);
    vy = 50'(sy >>> 14);
    vz = 50'(dz3_r);
    lo = -$signed({19'b0, geo.tol});
    hit = (vx >= lo) && (vx <= $signed({19'b0, lx3_r}))
       && (vy >= lo) && (vy <= $signed({19'b0, ly3_r}))
       && (vz >= lo) && (vz <= $signed({19'b0, lz3_r}));
    deeper = tok3_r.alive && hit && (32'(cell_level) < 32'(geo.nl));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r <= '0;
      tok2_r <= '0;
      tok3_r <= '0;
      tok4_r <= '0;
    end else begin
      tok1_r <= tok_in;
      tok2_r <= tok1_r;
      tok3_r <= tok2_r;
      tok4_r.valid   <= tok3_r.valid;
      tok4_r.alive   <= deeper;
      tok4_r.turbine <= tok3_r.turbine;
      tok4_r.depth   <= deeper ? DEPTH_W'(cell_level) + DEPTH_W'(1) : tok3_r.depth;
    end
  end

  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    dz_r  <= dz_nxt;
    lx2_r <= box_r.lx;
    ly2_r <= box_r.ly;
    lz2_r <= box_r.lz;
    pax_r <= geo.axis_a * dx_r;
    pby_r <= geo.axis_b * dy_r;
    pay_r <= geo.axis_a * dy_r;
    pbx_r <= geo.axis_b * dx_r;
    dz3_r <= dz_r;
    lx3_r <= lx2_r;
    ly3_r <= ly2_r;
    lz3_r <= lz2_r;
  end

  assign tok_out = tok4_r;

  a_tok_origin: assert property (@(posedge clk) disable iff (!rst_n)
    tok_out.valid |-> $past(tok_in.valid, 4))
    else $error("token left cell without entering");

  a_alive_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_out.valid && tok_out.alive) |->
      (tok_out.depth == DEPTH_W'(cell_level) + DEPTH_W'(1)))
    else $error("live token depth mismatch");

  a_alive_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_out.valid && tok_out.alive) |-> $past(tok_in.alive, 4))
    else $error("dead token came back to life");

endmodule

// ===== sv/nbrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// nbrc_ctrl
// Query sequencer: issues one turbine token per cycle into the cell row,
// collects the deepest level and forms the fraction with a serial divider.
// ----------------------------------------------------------------------------
module nbrc_ctrl
  import nbrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               query_go,
  input  logic [NT_W-1:0]    num_turbines,
  input  logic [NL_W-1:0]    num_levels,
  output logic               idle,
  output tok_t               tok_head,
  input  tok_t               tok_tail,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [DEPTH_W-1:0] res_level,
  output logic [FRAC_W-1:0]  res_frac
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_PREP  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   nt_r, iss_r, rcv_r;
  logic [NL_W-1:0]    nl_r;
  logic [DEPTH_W-1:0] best_r;
  logic [NUM_W-1:0]   num_r, quo_r;
  logic [NL_W:0]      rem_r;
  logic [4:0]         step_r;
  logic               out_valid_r;
  logic [DEPTH_W-1:0] out_level_r;
  logic [FRAC_W-1:0]  out_frac_r;
  logic [NL_W:0]      rem_sh;
  logic               rem_ge;

  assign idle = (state_r == ST_IDLE);
  assign rem_sh = {rem_r[NL_W-1:0], num_r[NUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, nl_r});

  always_comb begin
    tok_head         = '0;
    tok_head.valid   = (state_r == ST_ISSUE);
    tok_head.alive   = 1'b1;
    tok_head.turbine = iss_r[TURB_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (query_go) begin
        state_nxt = (num_turbines == '0) ? ST_PREP : ST_ISSUE;
      end
      ST_ISSUE: if (iss_r == nt_r - CNT_W'(1)) begin
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: if (tok_tail.valid && rcv_r == nt_r - CNT_W'(1)) begin
        state_nxt = ST_PREP;
      end
      ST_PREP:  state_nxt = ST_DIV;
      ST_DIV:   if (step_r == 5'(NUM_W - 1)) begin
        state_nxt = ST_DONE;
      end
      ST_DONE:  if (!out_valid_r || out_tready) begin
        state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      rcv_r       <= '0;
      best_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && query_go) begin
        iss_r  <= '0;
        rcv_r  <= '0;
        best_r <= '0;
      end else begin
        if (state_r == ST_ISSUE) begin
          iss_r <= iss_r + CNT_W'(1);
        end
        if (tok_tail.valid) begin
          rcv_r <= rcv_r + CNT_W'(1);
          if (tok_tail.depth > best_r) begin
            best_r <= tok_tail.depth;
          end
        end
      end
      if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // saturating counts and restoring divider
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && query_go) begin
      nt_r <= (32'(num_turbines) > MAX_TURBINES) ? CNT_W'(MAX_TURBINES)
                                                 : CNT_W'(num_turbines);
      nl_r <= (32'(num_levels) > MAX_LEVELS) ? NL_W'(MAX_LEVELS) : num_levels;
    end
    if (state_r == ST_PREP) begin
      num_r  <= {best_r, 16'b0} + NUM_W'(nl_r >> 1);
      rem_r  <= '0;
      quo_r  <= '0;
      step_r <= '0;
    end else if (state_r == ST_DIV) begin
      num_r  <= {num_r[NUM_W-2:0], 1'b0};
      rem_r  <= rem_ge ? rem_sh - {1'b0, nl_r} : rem_sh;
      quo_r  <= {quo_r[NUM_W-2:0], rem_ge};
      step_r <= step_r + 5'd1;
    end
    if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_level_r <= best_r;
      out_frac_r  <= (nl_r == '0) ? '0 : quo_r[FRAC_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign res_level  = out_level_r;
  assign res_frac   = out_frac_r;

  a_rcv_le_iss: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE || state_r == ST_DRAIN) |-> (rcv_r <= iss_r))
    else $error("more tokens returned than issued");

  a_all_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (iss_r == nt_r))
    else $error("drain entered before all turbines issued");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (32'(best_r) <= 32'(nl_r)))
    else $error("refine level above level count");

endmodule
